FILE: design/rsbe_pkg.sv
`timescale 1ns / 1ps

package rsbe_pkg;

   localparam int BYTE_W            = 8;
   localparam int INDEX_W           = 5;
   localparam int NROOTS_DEFAULT    = 8;
   localparam int NROOTS_MAX        = 32;
   localparam int CODE_N            = 255;
   localparam int QUEUE_DEPTH       = 2;
   localparam logic [8:0] GF_POLY   = 9'h11d;
   localparam logic [7:0] BLOCK_BYTES_RESET = 8'd247;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] x;
      logic [7:0] acc;
      x   = {1'b0, a};
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x[7:0];
         end
         x = {x[7:0], 1'b0};
         if (x[8]) begin
            x = x ^ GF_POLY;
         end
      end
      return acc;
   endfunction

   // coefficient k of the generator with roots alpha^0 .. alpha^(nroots-1)
   function automatic logic [7:0] gen_coef(input int nroots, input int k);
      logic [7:0] g [NROOTS_MAX+1];
      logic [7:0] root;
      for (int j = 0; j <= NROOTS_MAX; j++) begin
         g[j] = 8'h00;
      end
      g[0] = 8'h01;
      root = 8'h01;
      for (int i = 0; i < nroots; i++) begin
         g[i+1] = 8'h01;
         for (int j = i; j > 0; j--) begin
            g[j] = g[j-1] ^ gf_mul(g[j], root);
         end
         g[0] = gf_mul(g[0], root);
         root = gf_mul(root, 8'h02);
      end
      return g[k];
   endfunction

endpackage

FILE: design/rsbe_req_if.sv
`timescale 1ns / 1ps

interface rsbe_req_if;
   logic                        valid;
   logic                        ready;
   logic [rsbe_pkg::BYTE_W-1:0] data_byte;
   logic                        end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

FILE: design/rsbe_rsp_if.sv
`timescale 1ns / 1ps

interface rsbe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rsbe_pkg::BYTE_W-1:0]  parity_byte;
   logic [rsbe_pkg::INDEX_W-1:0] parity_index;
   logic                         last_parity;

   modport source (output valid, output parity_byte, output parity_index,
                   output last_parity, input ready);
   modport sink   (input valid, input parity_byte, input parity_index,
                   input last_parity, output ready);
endinterface

FILE: design/rsbe_front.sv
`timescale 1ns / 1ps

module rsbe_front #(
   parameter int NROOTS = rsbe_pkg::NROOTS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   rsbe_req_if.sink                              req_ch,
   input  logic [rsbe_pkg::BYTE_W-1:0]           block_bytes,
   input  rsbe_pkg::qstat_type                   qstat,
   output logic                                  push,
   output logic [NROOTS-1:0][rsbe_pkg::BYTE_W-1:0] push_data
);

   localparam int BW = rsbe_pkg::BYTE_W;
   localparam logic [BW-1:0] MAX_LEN = BW'(rsbe_pkg::CODE_N - NROOTS);

   logic [NROOTS-1:0][BW-1:0] parity_ff, parity_in, parity_next;
   logic [BW-1:0]             count_ff, count_in, count_next;
   logic [BW-1:0]             limit;
   logic [BW-1:0]             fb;
   logic                      accept;
   logic                      close;

   assign req_ch.ready = !qstat.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign fb           = req_ch.data_byte ^ parity_ff[0];

   for (genvar g = 0; g < NROOTS; g++) begin : g_lfsr
      localparam logic [BW-1:0] COEF = rsbe_pkg::gen_coef(NROOTS, NROOTS - 1 - g);
      if (g < NROOTS - 1) begin : g_mid
         assign parity_next[g] = parity_ff[g+1] ^ rsbe_pkg::gf_mul(fb, COEF);
      end else begin : g_top
         assign parity_next[g] = rsbe_pkg::gf_mul(fb, COEF);
      end
   end

   always_comb begin
      if (block_bytes == '0) begin
         limit = BW'(1);
      end else if (block_bytes > MAX_LEN) begin
         limit = MAX_LEN;
      end else begin
         limit = block_bytes;
      end
      count_next = count_ff + BW'(1);
      close      = req_ch.end_of_message || (count_next >= limit);
      push       = accept && close;
      push_data  = parity_next;
      parity_in  = parity_ff;
      count_in   = count_ff;
      if (accept) begin
         if (close) begin
            parity_in = '0;
            count_in  = '0;
         end else begin
            parity_in = parity_next;
            count_in  = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= '0;
         count_ff  <= '0;
      end else begin
         parity_ff <= parity_in;
         count_ff  <= count_in;
      end
   end

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      push |=> (count_ff == '0) && (parity_ff == '0))
      else $error("block close did not clear the parity state");

endmodule

FILE: design/rsbe_queue.sv
`timescale 1ns / 1ps

module rsbe_queue #(
   parameter int WIDTH = rsbe_pkg::NROOTS_DEFAULT * rsbe_pkg::BYTE_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   push_data,
   input  logic               pop,
   output logic [WIDTH-1:0]   pop_data,
   output rsbe_pkg::qstat_type qstat
);

   localparam int DEPTH = rsbe_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_data    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty queue");

endmodule

FILE: design/rsbe_back.sv
`timescale 1ns / 1ps

module rsbe_back #(
   parameter int NROOTS = rsbe_pkg::NROOTS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rsbe_pkg::qstat_type                   qstat,
   input  logic [NROOTS-1:0][rsbe_pkg::BYTE_W-1:0] pop_data,
   output logic                                  pop,
   rsbe_rsp_if.source                            rsp_ch
);

   localparam int BW    = rsbe_pkg::BYTE_W;
   localparam int IW    = rsbe_pkg::INDEX_W;
   localparam int IDX_W = $clog2(NROOTS);

   logic [NROOTS-1:0][BW-1:0] shreg_ff, shreg_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      busy_ff, busy_in;
   logic                      fire;
   logic                      last;

   assign last = (idx_ff == IDX_W'(NROOTS - 1));
   assign fire = busy_ff && rsp_ch.ready;
   assign pop  = !qstat.empty && (!busy_ff || (fire && last));

   assign rsp_ch.valid        = busy_ff;
   assign rsp_ch.parity_byte  = shreg_ff[0];
   assign rsp_ch.parity_index = IW'(idx_ff);
   assign rsp_ch.last_parity  = last;

   always_comb begin
      shreg_in = shreg_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (pop) begin
         shreg_in = pop_data;
         idx_in   = '0;
         busy_in  = 1'b1;
      end else if (fire) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            for (int k = 0; k < NROOTS - 1; k++) begin
               shreg_in[k] = shreg_ff[k+1];
            end
            shreg_in[NROOTS-1] = '0;
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

   a_mid_block_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && !last) |=> busy_ff && (idx_ff == $past(idx_ff) + IDX_W'(1)))
      else $error("parity sequence broke mid block");

   a_load_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      pop |=> busy_ff && (idx_ff == '0))
      else $error("new block did not start at index zero");

endmodule

FILE: design/reed_solomon_block_encoder_top.sv
`timescale 1ns / 1ps

// Reed-Solomon block encoder, GF(256), polynomial 0x11d, NROOTS parity symbols.
// req_ch takes one message byte per item; end_of_message closes the block early.
// Blocks close after block_bytes data bytes (0 acts as 1, values above
// 255-NROOTS act as 255-NROOTS). Data bytes are not echoed.
// rsp_ch gives NROOTS parity items per block, index 0 first, last_parity on the
// final one.
// csr_valid/csr_block_bytes writes the block length; csr_ready is always high.
// Write it only while no block is open and all parity has been taken.
// req_ch takes one byte per cycle while the queue has room; a block's parity
// leaves at one item per cycle while rsp_ch.ready is high. Parity of a block passes
// through the two-block queue, then the output shifter, before it is first valid.
// When rsp_ch stalls, the output holds and finished blocks collect in the queue;
// req_ch.ready drops only while that queue holds two blocks.
// Reset clears the parity registers and byte count, empties the queue and sets
// the block length to 247.
module reed_solomon_block_encoder_top #(
   parameter int NROOTS = rsbe_pkg::NROOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   rsbe_req_if.sink                    req_ch,
   rsbe_rsp_if.source                  rsp_ch,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rsbe_pkg::BYTE_W-1:0] csr_block_bytes
);

   localparam int BW = rsbe_pkg::BYTE_W;

   logic [BW-1:0]             block_bytes_ff, block_bytes_in;
   rsbe_pkg::qstat_type       qstat;
   logic                      push;
   logic                      pop;
   logic [NROOTS-1:0][BW-1:0] push_data;
   logic [NROOTS-1:0][BW-1:0] pop_data;

   assign csr_ready      = 1'b1;
   assign block_bytes_in = (csr_valid && csr_ready) ? csr_block_bytes : block_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= rsbe_pkg::BLOCK_BYTES_RESET;
      end else begin
         block_bytes_ff <= block_bytes_in;
      end
   end

   rsbe_front #(.NROOTS(NROOTS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .block_bytes (block_bytes_ff),
      .qstat       (qstat),
      .push        (push),
      .push_data   (push_data)
   );

   rsbe_queue #(.WIDTH(NROOTS * BW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   rsbe_back #(.NROOTS(NROOTS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int NSYM           = rsbe_pkg::NROOTS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 80;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PRINT_CAP      = 30;

   typedef struct {
      logic [rsbe_pkg::BYTE_W-1:0]  pbyte;
      logic [rsbe_pkg::INDEX_W-1:0] pindex;
      logic                         plast;
   } parity_sym_type;

   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x   = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         x = {x[6:0], 1'b0} ^ (x[7] ? rsbe_pkg::GF_POLY[7:0] : 8'h00);
      end
      return acc;
   endfunction

   class parity_board_type;
      logic [7:0]     gen [NSYM+1];
      logic [7:0]     lfsr [NSYM];
      int unsigned    fill;
      logic [7:0]     len_cfg;
      parity_sym_type parity_due [$];
      int             errors;
      int             bytes_seen;
      int             blocks_closed;
      int             syms_checked;

      function new();
         logic [7:0] root;
         root = 8'h01;
         foreach (gen[j]) begin
            gen[j] = 8'h00;
         end
         gen[0] = 8'h01;
         for (int i = 0; i < NSYM; i++) begin
            gen[i+1] = 8'h01;
            for (int j = i; j > 0; j--) begin
               gen[j] = gen[j-1] ^ gf_times(gen[j], root);
            end
            gen[0] = gf_times(gen[0], root);
            root = gf_times(root, 8'h02);
         end
         foreach (lfsr[j]) begin
            lfsr[j] = 8'h00;
         end
         fill          = 0;
         len_cfg       = rsbe_pkg::BLOCK_BYTES_RESET;
         errors        = 0;
         bytes_seen    = 0;
         blocks_closed = 0;
         syms_checked  = 0;
      endfunction

      function void set_len_cfg(input logic [7:0] v);
         len_cfg = v;
      endfunction

      // advance the parity LFSR; queue the parity when the block closes
      function void note_byte(input logic [7:0] d, input logic eom);
         logic [7:0]     fb;
         int unsigned    span;
         parity_sym_type s;
         fb = d ^ lfsr[0];
         for (int j = 1; j < NSYM; j++) begin
            lfsr[j-1] = lfsr[j] ^ gf_times(fb, gen[NSYM-j]);
         end
         lfsr[NSYM-1] = gf_times(fb, gen[0]);
         span = (len_cfg == 8'd0) ? 1 : len_cfg;
         if (span > rsbe_pkg::CODE_N - NSYM) begin
            span = rsbe_pkg::CODE_N - NSYM;
         end
         fill++;
         bytes_seen++;
         if (!eom && fill < span) begin
            return;
         end
         for (int k = 0; k < NSYM; k++) begin
            s.pbyte  = lfsr[k];
            s.pindex = rsbe_pkg::INDEX_W'(k);
            s.plast  = (k == NSYM - 1);
            parity_due.push_back(s);
            lfsr[k] = 8'h00;
         end
         fill = 0;
         blocks_closed++;
      endfunction

      task flag_mismatch(input string msg);
         if (errors < PRINT_CAP) begin
            $display("%0t mismatch: %s", $realtime, msg);
         end
         errors++;
      endtask

      task check_parity(input logic [7:0] b, input logic [4:0] idx, input logic lst);
         parity_sym_type want;
         if (parity_due.size() == 0) begin
            flag_mismatch($sformatf("parity item %h index %0d with nothing pending", b, idx));
            return;
         end
         want = parity_due.pop_front();
         syms_checked++;
         if (b !== want.pbyte) begin
            flag_mismatch($sformatf("parity_byte %h, want %h (index %0d)",
                                    b, want.pbyte, want.pindex));
         end
         if (idx !== want.pindex) begin
            flag_mismatch($sformatf("parity_index %0d, want %0d", idx, want.pindex));
         end
         if (lst !== want.plast) begin
            flag_mismatch($sformatf("last_parity %b, want %b (index %0d)",
                                    lst, want.plast, want.pindex));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_block_bytes;

   rsbe_req_if req_ch();
   rsbe_rsp_if rsp_ch();

   reed_solomon_block_encoder_top #(
      .NROOTS(NSYM)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_block_bytes(csr_block_bytes)
   );

   parity_board_type sb;

   bit          calm         = 1'b0;
   int unsigned hold_asks    = 0;
   int unsigned hold_done    = 0;
   int unsigned hold_left    = 0;
   int unsigned gap_left     = 0;
   int unsigned quiet_cycles = 0;
   int          len_writes   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: long hold on request, otherwise short random stalls while not calm
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_asks != hold_done) begin
         hold_done    <= hold_done + 1;
         hold_left    <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (gap_left != 0) begin
         gap_left     <= gap_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         gap_left     <= $urandom_range(0, 4);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_parity(rsp_ch.parity_byte, rsp_ch.parity_index, rsp_ch.last_parity);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic eom);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.data_byte      <= d;
      req_ch.end_of_message <= eom;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_byte(d, eom);
   endtask

   task automatic drain_parity();
      req_ch.valid <= 1'b0;
      while (sb.parity_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_len_cfg(input logic [7:0] v);
      drain_parity();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_block_bytes <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_len_cfg(v);
      len_writes++;
   endtask

   // random message bytes; the final item always closes the open block
   task automatic random_messages(input int count);
      logic eom;
      for (int i = 0; i < count; i++) begin
         eom = (i == count - 1) || ($urandom_range(0, 5) == 0);
         send_byte(8'($urandom_range(0, 255)), eom);
      end
   endtask

   initial begin
      sb = new();
      req_ch.valid          = 1'b0;
      req_ch.data_byte      = 8'h00;
      req_ch.end_of_message = 1'b0;
      csr_valid             = 1'b0;
      csr_block_bytes       = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'haa, 1'b1);

      write_len_cfg(8'd0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h5a, 1'b1);

      write_len_cfg(8'd1);
      send_byte(8'h3c, 1'b0);
      send_byte(8'hc3, 1'b1);

      write_len_cfg(8'd2);
      send_byte(8'h11, 1'b1);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);

      // saturated length, short messages
      write_len_cfg(8'd255);
      random_messages(10);

      write_len_cfg(8'd3);
      random_messages(16);

      // hold the result side while every byte closes a block
      write_len_cfg(8'd1);
      hold_asks <= hold_asks + 1;
      random_messages(20);

      write_len_cfg(8'd248);
      random_messages(10);

      write_len_cfg(8'($urandom_range(4, 12)));
      random_messages(25);

      calm <= 1'b1;
      write_len_cfg(8'($urandom_range(13, 40)));
      random_messages(20);

      drain_parity();
      repeat (12) @(posedge clock);

      $display("run covered %0d message bytes in %0d blocks, %0d parity items checked",
               sb.bytes_seen, sb.blocks_closed, sb.syms_checked);
      $display("block length written %0d times, from 0 to 255, with one long output stall",
               len_writes);
      if (sb.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
